// File: rtl/core/lsb_message_extractor_defines.svh
// Assertion helpers shared by the extractor RTL.
// Each use expands to one labeled concurrent assertion on clk_i, off during reset.
`ifndef LSB_MESSAGE_EXTRACTOR_DEFINES_SVH
`define LSB_MESSAGE_EXTRACTOR_DEFINES_SVH

// Same-cycle implication.
`define LME_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LME_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lme_pkg.sv
`timescale 1ns / 1ps

package lme_pkg;

  localparam int unsigned MaxMarkerChars = 8;
  localparam int unsigned LengthDigits   = 6;

  localparam int unsigned TextW    = 64;
  localparam int unsigned CharsW   = 4;
  localparam int unsigned LenPixW  = 5;
  localparam int unsigned MsgLenW  = 20;
  localparam int unsigned RegPixW  = 5;

  // Configuration register indexes
  localparam logic [1:0] CFG_MARKER_TEXT  = 2'd0;
  localparam logic [1:0] CFG_MARKER_CHARS = 2'd1;
  localparam logic [1:0] CFG_LENGTH_PIX   = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_BYTE     = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [LenPixW-1:0] LEN_PIX_MIN = 5'd16;
  localparam logic [LenPixW-1:0] LEN_PIX_MAX = 5'd18;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       is_last;
  } result_t;

  typedef struct packed {
    logic [TextW-1:0]   marker_text;
    logic [CharsW-1:0]  marker_chars;
    logic [LenPixW-1:0] length_field_pixels;
  } cfg_t;

  // Pixels of the marker region: floor(8*c/3)+1 for c = 1..8.
  function automatic logic [RegPixW-1:0] marker_pixels(input logic [CharsW-1:0] c);
    logic [RegPixW-1:0] p;
    case (c)
      4'd1:    p = 5'd3;
      4'd2:    p = 5'd6;
      4'd3:    p = 5'd9;
      4'd4:    p = 5'd11;
      4'd5:    p = 5'd14;
      4'd6:    p = 5'd17;
      4'd7:    p = 5'd19;
      default: p = 5'd22;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/core/lme_cfg_regs.sv
`timescale 1ns / 1ps

module lme_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [lme_pkg::TextW-1:0]  cfg_data_i,
  output lme_pkg::cfg_t              cfg_o
);

  lme_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.marker_text         <= '0;
      cfg_q.marker_chars        <= 4'd8;
      cfg_q.length_field_pixels <= 5'd17;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lme_pkg::CFG_MARKER_TEXT: begin
          cfg_q.marker_text <= cfg_data_i;
        end
        lme_pkg::CFG_MARKER_CHARS: begin
          cfg_q.marker_chars <= cfg_data_i[lme_pkg::CharsW-1:0];
        end
        lme_pkg::CFG_LENGTH_PIX: begin
          cfg_q.length_field_pixels <= cfg_data_i[lme_pkg::LenPixW-1:0];
        end
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/lme_core.sv
`timescale 1ns / 1ps
`include "lsb_message_extractor_defines.svh"

module lme_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  lme_pkg::pixel_t  pix_i,
  input  lme_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  output lme_pkg::result_t res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MARKER,
    PH_LENGTH,
    PH_MESSAGE
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [7:0]                      acc_q, acc_d;
  logic [2:0]                      fill_q, fill_d;
  logic [lme_pkg::MsgLenW-1:0]     bytes_q, bytes_d;
  logic [lme_pkg::RegPixW-1:0]     pix_left_q, pix_left_d;
  logic [2:0]                      mpos_q, mpos_d;
  logic [lme_pkg::MsgLenW-1:0]     mlen_q, mlen_d;
  logic                            stopped_q, stopped_d;

  logic [lme_pkg::CharsW-1:0]      chars;
  logic [lme_pkg::LenPixW-1:0]     len_pix;
  logic [2:0]                      bits;
  logic                            byte_done;
  logic [7:0]                      byte_val;
  logic [7:0]                      shifted;
  logic [2:0]                      sel;
  logic [7:0]                      expect_byte;
  logic [3:0]                      digit;

  always_comb begin
    chars = cfg_i.marker_chars;
    if (chars == '0) begin
      chars = 4'd1;
    end else if (chars > 4'(lme_pkg::MaxMarkerChars)) begin
      chars = 4'(lme_pkg::MaxMarkerChars);
    end
    len_pix = cfg_i.length_field_pixels;
    if (len_pix < lme_pkg::LEN_PIX_MIN) begin
      len_pix = lme_pkg::LEN_PIX_MIN;
    end else if (len_pix > lme_pkg::LEN_PIX_MAX) begin
      len_pix = lme_pkg::LEN_PIX_MAX;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    fill_d      = fill_q;
    bytes_d     = bytes_q;
    pix_left_d  = pix_left_q;
    mpos_d      = mpos_q;
    mlen_d      = mlen_q;
    stopped_d   = stopped_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    byte_done   = 1'b0;
    byte_val    = '0;
    shifted     = '0;
    sel         = '0;
    expect_byte = '0;
    digit       = '0;
    bits        = {pix_i.blue[0], pix_i.green[0], pix_i.red[0]};

    // restart on the first pixel of an image
    if (pix_i.frame_start) begin
      phase_d    = PH_MARKER;
      pix_left_d = lme_pkg::marker_pixels(chars);
      bytes_d    = lme_pkg::MsgLenW'(chars);
      acc_d      = '0;
      fill_d     = '0;
      mpos_d     = '0;
      mlen_d     = '0;
      stopped_d  = 1'b0;
    end

    if (phase_d != PH_IDLE) begin
      // shift in red, green, blue; at most one byte completes per pixel
      for (int i = 0; i < 3; i++) begin
        if (bytes_d != '0) begin
          shifted = {acc_d[6:0], bits[i]};
          if (fill_d == 3'd7) begin
            byte_done = 1'b1;
            byte_val  = shifted;
            acc_d     = '0;
            fill_d    = '0;
            bytes_d   = bytes_d - lme_pkg::MsgLenW'(1);
          end else begin
            acc_d  = shifted;
            fill_d = fill_d + 3'd1;
          end
        end
      end

      if (byte_done) begin
        case (phase_d)
          PH_MARKER: begin
            sel         = 3'(chars - 4'd1 - {1'b0, mpos_d});
            expect_byte = cfg_i.marker_text[{sel, 3'b000} +: 8];
            if (byte_val != expect_byte) begin
              res_valid_o    = 1'b1;
              res_o.status   = lme_pkg::STATUS_MISMATCH;
              res_o.is_last  = 1'b1;
              phase_d        = PH_IDLE;
            end else begin
              mpos_d = mpos_d + 3'd1;
            end
          end
          PH_LENGTH: begin
            digit = byte_val[3:0];
            if (!stopped_d && byte_val >= lme_pkg::CHAR_ZERO
                && byte_val <= lme_pkg::CHAR_NINE) begin
              mlen_d = {mlen_d[16:0], 3'b000} + {mlen_d[18:0], 1'b0}
                       + lme_pkg::MsgLenW'(digit);
            end else begin
              stopped_d = 1'b1;
            end
          end
          PH_MESSAGE: begin
            res_valid_o    = 1'b1;
            res_o.out_byte = byte_val;
            res_o.status   = lme_pkg::STATUS_BYTE;
            res_o.is_last  = (bytes_d == '0);
            if (bytes_d == '0) begin
              phase_d = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end

      // the message region always ends on its last byte, so only the
      // marker and length regions count pixels
      if (phase_d == PH_MARKER || phase_d == PH_LENGTH) begin
        if (pix_left_d != '0) begin
          pix_left_d = pix_left_d - lme_pkg::RegPixW'(1);
        end
        if (pix_left_d == '0) begin
          acc_d  = '0;
          fill_d = '0;
          if (phase_d == PH_MARKER) begin
            phase_d    = PH_LENGTH;
            pix_left_d = len_pix;
            bytes_d    = lme_pkg::MsgLenW'(lme_pkg::LengthDigits);
            mlen_d     = '0;
            stopped_d  = 1'b0;
          end else if (mlen_d == '0) begin
            res_valid_o   = 1'b1;
            res_o.status  = lme_pkg::STATUS_EMPTY;
            res_o.is_last = 1'b1;
            phase_d       = PH_IDLE;
          end else begin
            phase_d = PH_MESSAGE;
            bytes_d = mlen_d;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      acc_q      <= '0;
      fill_q     <= '0;
      bytes_q    <= '0;
      pix_left_q <= '0;
      mpos_q     <= '0;
      mlen_q     <= '0;
      stopped_q  <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      fill_q     <= fill_d;
      bytes_q    <= bytes_d;
      pix_left_q <= pix_left_d;
      mpos_q     <= mpos_d;
      mlen_q     <= mlen_d;
      stopped_q  <= stopped_d;
    end
  end

  `LME_ASSERT_NXT(a_idle_after_last, step_i && res_valid_o && res_o.is_last, phase_q == PH_IDLE, "block not idle after final result")
  `LME_ASSERT_IMP(a_message_has_bytes, phase_q == PH_MESSAGE, bytes_q != '0, "message region with no bytes left")
  `LME_ASSERT_IMP(a_idle_no_result, step_i && phase_q == PH_IDLE && !pix_i.frame_start, !res_valid_o, "result while idle")

endmodule

// File: rtl/core/lsb_message_extractor.sv
// LSB message extractor.
// Input channel (in_valid_i / in_stall_o / in_word_i): one RGB pixel per word,
// in image order; frame_start marks the first pixel of an image and restarts
// extraction. Output channel (out_valid_o / out_stall_i / out_word_o): one
// word per extracted message byte (status 0), or a single final word for a
// marker mismatch (status 1) or an empty message (status 2). is_last flags
// the final word of an image; pixels after it are ignored until frame_start.
// A pixel is taken into the input register and its result into the output
// register; the input register, the step logic and the output register form
// a two-stage pipeline. Throughput: one pixel per cycle while not stalled.
// A stalled receiver holds the output word; one more pixel waits in the input
// register, after which in_stall_o rises until the output word is taken.
// Reset clears the pipeline, returns the extractor to idle and loads the
// configuration defaults (marker text 0, 8 marker characters, 17 length
// pixels). The user must write configuration through cfg_we_i / cfg_index_i /
// cfg_data_i only while no pixel is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`include "lsb_message_extractor_defines.svh"

module lsb_message_extractor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lme_pkg::pixel_t           in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lme_pkg::result_t          out_word_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [lme_pkg::TextW-1:0] cfg_data_i
);

  lme_pkg::cfg_t    cfg;
  lme_pkg::pixel_t  in_word_q;
  logic             in_valid_q;
  lme_pkg::result_t out_word_q;
  logic             out_valid_q;
  logic             step;
  logic             res_valid;
  lme_pkg::result_t res;

  // advance the input word when the output register is free or being taken
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  lme_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lme_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pix_i       (in_word_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res_valid;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `LME_ASSERT_IMP(a_stall_only_when_full, in_stall_o, in_valid_q && out_valid_q && out_stall_i, "input stalled with room in the pipeline")
  `LME_ASSERT_IMP(a_status_code, out_valid_o, out_word_o.status == lme_pkg::STATUS_BYTE || out_word_o.status == lme_pkg::STATUS_MISMATCH || out_word_o.status == lme_pkg::STATUS_EMPTY, "undefined status code")
  `LME_ASSERT_IMP(a_error_is_final, out_valid_o && out_word_o.status != lme_pkg::STATUS_BYTE, out_word_o.is_last && out_word_o.out_byte == 8'h00, "status word not final or carries a byte")
  `LME_ASSERT_NXT(a_held_word_kept, out_valid_q && out_stall_i, out_valid_q, "stalled output word lost")

endmodule
